### hdl/spc_pkg.sv
package spc_pkg;

   // default build limits
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_NODES  = 65536;

   // field widths
   localparam int PIXEL_W      = 8;
   localparam int CSR_DATA_W   = 11;
   localparam int CSR_INDEX_W  = 2;
   localparam int DIM_CALC_W   = 14;
   localparam int POINT_TYPE_W = 3;
   localparam int NODE_IDX_W   = 16;
   localparam int MASK_W       = 8;
   localparam int WINDOW_W     = 9;
   localparam int LINE_PAIR_W  = 2;

   // result queue
   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH + 1);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   typedef enum logic [POINT_TYPE_W-1:0] {
      PT_NONE         = 3'd0,
      PT_ISOLATED     = 3'd1,
      PT_TERMINAL     = 3'd2,
      PT_INTERSECTION = 3'd3,
      PT_MIDDLE       = 3'd4
   } point_type_type;

   // position of the window centre relative to the image border
   typedef struct packed {
      logic centre_valid;
      logic left_ok;
      logic right_ok;
      logic top_ok;
      logic bot_ok;
      logic last;
   } flags_type;

   typedef struct packed {
      flags_type             flags;
      logic [WINDOW_W-1:0]   window;
   } centre_type;

   typedef struct packed {
      point_type_type          point_type;
      logic [NODE_IDX_W-1:0]   node_index;
      logic [MASK_W-1:0]       neighbor_mask;
      logic                    node_saturated;
      logic                    frame_last;
   } result_type;

endpackage

### hdl/spc_if.sv
interface spc_req_if;
   import spc_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface spc_rsp_if;
   import spc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [POINT_TYPE_W-1:0] point_type;
   logic [NODE_IDX_W-1:0]   node_index;
   logic [MASK_W-1:0]       neighbor_mask;
   logic                    node_saturated;
   logic                    frame_last;

   modport source (output valid, output point_type, output node_index,
                   output neighbor_mask, output node_saturated, output frame_last,
                   input ready);
   modport sink   (input valid, input point_type, input node_index,
                   input neighbor_mask, input node_saturated, input frame_last,
                   output ready);
endinterface

### hdl/spc_ram.sv
module spc_ram #(
   parameter int WIDTH = spc_pkg::LINE_PAIR_W,
   parameter int DEPTH = spc_pkg::DEF_MAX_WIDTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/spc_front.sv
module spc_front #(
   parameter int MAX_WIDTH  = spc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = spc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [spc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [spc_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             req_accept,
   input  logic [spc_pkg::PIXEL_W-1:0]      pixel_value,
   output logic                             s1_busy,
   output logic                             restart,
   output spc_pkg::centre_type              centre
);
   import spc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 2);

   logic [WW-1:0]          w_ff, w_in;
   logic [HW-1:0]          h_ff, h_in;
   logic [CW-1:0]          c_ff, c_in;
   logic [RW-1:0]          r_ff, r_in;
   logic [WINDOW_W-1:0]    window_ff, window_in;
   logic                   s1_valid_ff;
   logic [CW-1:0]          s1_addr_ff;
   logic                   s1_bit_ff;
   flags_type              s1_flags_ff, flags_in;
   logic                   fwd_ff, fwd_in;
   logic [LINE_PAIR_W-1:0] fwd_data_ff;
   centre_type             centre_ff, centre_in;

   logic [DIM_CALC_W-1:0]  dim_raw, w_clamp, h_clamp;
   logic [CW-1:0]          w_m1, x;
   logic [RW-1:0]          h_ext, h_p1, h_m1, y;
   logic                   c_zero, pos_valid, bit_in;
   logic [LINE_PAIR_W-1:0] ram_rdata, pair, wr_data;

   // clamp of a dimension write to 1..max
   always_comb begin
      dim_raw = DIM_CALC_W'(csr_data);
      w_clamp = dim_raw;
      h_clamp = dim_raw;
      if (dim_raw == '0) begin
         w_clamp = DIM_CALC_W'(1);
         h_clamp = DIM_CALC_W'(1);
      end
      if (dim_raw > DIM_CALC_W'(MAX_WIDTH)) begin
         w_clamp = DIM_CALC_W'(MAX_WIDTH);
      end
      if (dim_raw > DIM_CALC_W'(MAX_HEIGHT)) begin
         h_clamp = DIM_CALC_W'(MAX_HEIGHT);
      end
   end

   // width and height register writes restart the frame
   always_comb begin
      w_in    = w_ff;
      h_in    = h_ff;
      restart = 1'b0;
      if (csr_write_en) begin
         if (csr_index == REG_IMAGE_WIDTH) begin
            w_in    = WW'(w_clamp);
            restart = 1'b1;
         end else if (csr_index == REG_IMAGE_HEIGHT) begin
            h_in    = HW'(h_clamp);
            restart = 1'b1;
         end
      end
   end

   // window centre position for the request being taken
   always_comb begin
      h_ext     = RW'(h_ff);
      h_p1      = h_ext + RW'(1);
      h_m1      = h_ext - RW'(1);
      w_m1      = CW'(w_ff - WW'(1));
      c_zero    = (c_ff == '0);
      x         = c_zero ? w_m1 : c_ff - CW'(1);
      y         = c_zero ? r_ff - RW'(2) : r_ff - RW'(1);
      pos_valid = c_zero ? (r_ff >= RW'(2) && r_ff <= h_p1)
                         : (r_ff != '0 && r_ff <= h_ext);
      bit_in    = (r_ff < h_ext) && (pixel_value != '0);

      flags_in.centre_valid = pos_valid;
      flags_in.left_ok      = (x != '0);
      flags_in.right_ok     = (x != w_m1);
      flags_in.top_ok       = (y != '0);
      flags_in.bot_ok       = (y != h_m1);
      flags_in.last         = pos_valid && (x == w_m1) && (y == h_m1);
   end

   // raster position advance
   always_comb begin
      c_in = c_ff;
      r_in = r_ff;
      if (restart) begin
         c_in = '0;
         r_in = '0;
      end else if (req_accept) begin
         if (r_ff >= h_p1) begin
            c_in = '0;
            r_in = '0;
         end else if (c_ff == w_m1) begin
            c_in = '0;
            r_in = r_ff + RW'(1);
         end else begin
            c_in = c_ff + CW'(1);
         end
      end
   end

   // line store: each entry holds {row before previous, previous row}
   spc_ram #(
      .WIDTH (LINE_PAIR_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_addr (c_ff),
      .rd_data (ram_rdata)
   );

   // forward the write that lands in the same cycle as the read
   always_comb begin
      pair    = fwd_ff ? fwd_data_ff : ram_rdata;
      wr_data = {pair[0], s1_bit_ff};
      fwd_in  = req_accept && s1_valid_ff && (s1_addr_ff == c_ff);
   end

   // shift the new column into the window
   always_comb begin
      window_in = window_ff;
      if (restart) begin
         window_in = '0;
      end else if (s1_valid_ff) begin
         window_in = {s1_bit_ff, pair[0], pair[1], window_ff[WINDOW_W-1:3]};
      end
      centre_in.flags              = s1_flags_ff;
      centre_in.flags.centre_valid = s1_valid_ff && s1_flags_ff.centre_valid;
      centre_in.window             = window_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff        <= WW'(MAX_WIDTH);
         h_ff        <= HW'(MAX_HEIGHT);
         c_ff        <= '0;
         r_ff        <= '0;
         window_ff   <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         centre_ff   <= '0;
      end else begin
         w_ff        <= w_in;
         h_ff        <= h_in;
         c_ff        <= c_in;
         r_ff        <= r_in;
         window_ff   <= window_in;
         s1_valid_ff <= req_accept;
         fwd_ff      <= fwd_in;
         centre_ff   <= centre_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      s1_addr_ff  <= c_ff;
      s1_bit_ff   <= bit_in;
      s1_flags_ff <= flags_in;
      fwd_data_ff <= wr_data;
   end

   assign s1_busy = s1_valid_ff;
   assign centre  = centre_ff;

`ifndef ASSERT_OFF
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      WW'(c_ff) < w_ff)
      else $error("column position beyond image width");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      r_ff <= RW'(h_ff) + RW'(1))
      else $error("row position beyond frame plus flush row");

   a_fwd_same_entry: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_valid_ff && s1_addr_ff == $past(s1_addr_ff))
      else $error("forwarded line data for a different entry");
`endif
endmodule

### hdl/spc_classify.sv
module spc_classify #(
   parameter int MAX_NODES = spc_pkg::DEF_MAX_NODES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 restart,
   input  spc_pkg::centre_type  centre,
   output logic                 push,
   output spc_pkg::result_type  result
);
   import spc_pkg::*;

   localparam int NW = $clog2(MAX_NODES + 1);

   logic [NW-1:0]          node_count_ff, node_count_in;
   logic [NW-1:0]          nidx;
   logic [NW+NODE_IDX_W-1:0] nidx_wide;
   logic [WINDOW_W-1:0]    w;
   flags_type              f;
   logic [MASK_W-1:0]      nb_raw, clear, nb;
   logic [3:0]             cnt;
   point_type_type         ptype;
   logic                   sat;

   // neighbours inside the image, then corner removal
   always_comb begin
      w = centre.window;
      f = centre.flags;
      nb_raw[0] = f.top_ok & w[3];
      nb_raw[1] = f.top_ok & f.right_ok & w[6];
      nb_raw[2] = f.right_ok & w[7];
      nb_raw[3] = f.bot_ok & f.right_ok & w[8];
      nb_raw[4] = f.bot_ok & w[5];
      nb_raw[5] = f.bot_ok & f.left_ok & w[2];
      nb_raw[6] = f.left_ok & w[1];
      nb_raw[7] = f.top_ok & f.left_ok & w[0];

      clear    = '0;
      clear[1] = nb_raw[0] | nb_raw[2];
      clear[3] = nb_raw[2] | nb_raw[4];
      clear[5] = nb_raw[4] | nb_raw[6];
      clear[7] = nb_raw[6] | nb_raw[0];
      nb       = nb_raw & ~clear;

      cnt = 4'(nb[0]) + 4'(nb[1]) + 4'(nb[2]) + 4'(nb[3])
          + 4'(nb[4]) + 4'(nb[5]) + 4'(nb[6]) + 4'(nb[7]);
   end

   // class by neighbour count
   always_comb begin
      ptype = PT_NONE;
      if (w[4]) begin
         case (cnt)
            4'd0:    ptype = PT_ISOLATED;
            4'd1:    ptype = PT_TERMINAL;
            4'd2:    ptype = PT_MIDDLE;
            default: ptype = PT_INTERSECTION;
         endcase
      end
   end

   // node numbering with saturation, cleared after the last pixel and on restart
   always_comb begin
      nidx          = '0;
      sat           = 1'b0;
      node_count_in = node_count_ff;
      if (restart) begin
         node_count_in = '0;
      end else if (f.centre_valid) begin
         if (ptype == PT_TERMINAL || ptype == PT_INTERSECTION) begin
            if (node_count_ff >= NW'(MAX_NODES)) begin
               nidx = NW'(MAX_NODES - 1);
               sat  = 1'b1;
            end else begin
               nidx          = node_count_ff;
               node_count_in = node_count_ff + NW'(1);
            end
         end
         if (f.last) begin
            node_count_in = '0;
         end
      end
   end

   always_comb begin
      nidx_wide             = {{NODE_IDX_W{1'b0}}, nidx};
      push                  = f.centre_valid;
      result.point_type     = ptype;
      result.node_index     = nidx_wide[NODE_IDX_W-1:0];
      result.neighbor_mask  = w[4] ? nb : '0;
      result.node_saturated = sat;
      result.frame_last     = f.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      node_count_ff <= NW'(MAX_NODES))
      else $error("node count beyond maximum");

   a_sat_only_full: assert property (@(posedge clock) disable iff (reset)
      push && result.node_saturated |-> node_count_ff == NW'(MAX_NODES))
      else $error("saturation flagged below maximum node count");

   a_index_only_nodes: assert property (@(posedge clock) disable iff (reset)
      push && !(result.point_type == PT_TERMINAL || result.point_type == PT_INTERSECTION)
      |-> result.node_index == '0 && !result.node_saturated)
      else $error("node index on a pixel that is not a node");
`endif
endmodule

### hdl/spc_rsp_fifo.sv
module spc_rsp_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  spc_pkg::result_type             push_data,
   input  logic                            pop,
   output logic                            not_empty,
   output spc_pkg::result_type             head,
   output logic [spc_pkg::RSP_CNT_W-1:0]   count
);
   import spc_pkg::*;

   result_type           mem_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 do_pop;

   // pointer and fill count update
   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign count     = count_ff;
endmodule

### hdl/skeleton_pixel_classifier_top.sv
// Throughput: one request per clock, limited by the single read and single write of the
// line RAM that each request needs, while the result queue has credit for the request.
// A pixel's result goes through the stage-1, centre and result queue registers after the
// request that completes its 3x3 window, i.e. image_width+1 requests after the pixel itself.
// Synchronous reset clears position counters, window, node count and the result queue;
// the line RAM keeps its contents. A width or height register write restarts the frame.
module skeleton_pixel_classifier_top #(
   parameter int MAX_WIDTH  = spc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = spc_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_NODES  = spc_pkg::DEF_MAX_NODES
) (
   input  logic                            clock,
   input  logic                            reset,
   spc_req_if.sink                         req_if,
   spc_rsp_if.source                       rsp_if,
   input  logic                            csr_write_en,
   input  logic [spc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [spc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import spc_pkg::*;

   logic                 req_accept;
   logic                 s1_busy;
   logic                 restart;
   centre_type           centre;
   logic                 push;
   result_type           result;
   result_type           head;
   logic                 not_empty;
   logic [RSP_CNT_W-1:0] count;
   logic [RSP_CNT_W:0]   in_flight;

   // credit check: queue entries plus requests still in the pipe
   always_comb begin
      in_flight = (RSP_CNT_W + 1)'(count) + (RSP_CNT_W + 1)'(s1_busy)
                + (RSP_CNT_W + 1)'(centre.flags.centre_valid);
      req_if.ready = (in_flight < (RSP_CNT_W + 1)'(RSP_FIFO_DEPTH));
      req_accept   = req_if.valid && req_if.ready;
   end

   spc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_accept   (req_accept),
      .pixel_value  (req_if.pixel_value),
      .s1_busy      (s1_busy),
      .restart      (restart),
      .centre       (centre)
   );

   spc_classify #(
      .MAX_NODES (MAX_NODES)
   ) u_classify (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .centre  (centre),
      .push    (push),
      .result  (result)
   );

   spc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .pop       (rsp_if.ready),
      .not_empty (not_empty),
      .head      (head),
      .count     (count)
   );

   // result channel
   always_comb begin
      rsp_if.valid          = not_empty;
      rsp_if.point_type     = head.point_type;
      rsp_if.node_index     = head.node_index;
      rsp_if.neighbor_mask  = head.neighbor_mask;
      rsp_if.node_saturated = head.node_saturated;
      rsp_if.frame_last     = head.frame_last;
   end
endmodule
